// ===== rtl/u8u16_pkg.sv =====
// Shared types and constants for the UTF-8 to UTF-16BE converter.
// Used by the front, queue, back and top-level modules; depends on nothing.
package u8u16_pkg;

  // Depth of the queue between the decoder front and the unit back.
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned PtrW      = $clog2(FifoDepth);
  localparam int unsigned CntW      = $clog2(FifoDepth + 1);

  // Width of a gathered code point.
  localparam int unsigned PointW = 21;

  // UTF-8 lead and continuation byte masks and patterns.
  localparam logic [7:0] ContMask  = 8'hC0;
  localparam logic [7:0] ContPat   = 8'h80;
  localparam logic [7:0] Lead2Mask = 8'hE0;
  localparam logic [7:0] Lead2Pat  = 8'hC0;
  localparam logic [7:0] Lead3Mask = 8'hF0;
  localparam logic [7:0] Lead3Pat  = 8'hE0;
  localparam logic [7:0] Lead4Mask = 8'hF8;
  localparam logic [7:0] Lead4Pat  = 8'hF0;

  // UTF-16 surrogate constants.
  localparam logic [PointW-1:0] SuppBase = 21'h10000;
  localparam logic [15:0]       HiSurr   = 16'hD800;
  localparam logic [15:0]       LoSurr   = 16'hDC00;

  // One decoded item as it travels from the front to the back.
  typedef struct packed {
    logic              mark;   // end marker, no code point
    logic [PointW-1:0] point;  // complete code point
    logic              fin;    // caused by the string's last byte
  } entry_t;

endpackage

// ===== rtl/utf8_to_utf16be_converter.sv =====
// UTF-8 to UTF-16BE converter: one byte in per cycle while the queue has room, one
// 16-bit unit out per cycle while results are popped and the queue holds entries.
// Queued points fill the result register; a surrogate pair goes out high, then low.
// The four-entry queue between decoder and back absorbs pairs and result stalls.
// Reset (rst_ni low, asynchronous) empties the queue and clears the decoder state.
// Depends on u8u16_pkg, u8u16_front, u8u16_fifo and u8u16_back.
module utf8_to_utf16be_converter
  import u8u16_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_byte_i,
  input  logic        final_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] code_unit_o,
  output logic        unit_valid_o,
  output logic        string_end_o,
  output logic        run_last_o
);

  logic   accept;
  logic   q_push, q_pop, q_full, q_empty;
  entry_t q_wdata, q_rdata;

  // A byte transfer happens when push is high and the queue has room.
  assign full   = q_full;
  assign accept = push & ~q_full;

  u8u16_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .in_byte_i    (in_byte_i),
    .final_byte_i (final_byte_i),
    .push_o       (q_push),
    .entry_o      (q_wdata)
  );

  u8u16_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  u8u16_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .entry_i      (q_rdata),
    .avail_i      (~q_empty),
    .take_o       (q_pop),
    .pop_i        (pop),
    .empty_o      (empty),
    .code_unit_o  (code_unit_o),
    .unit_valid_o (unit_valid_o),
    .string_end_o (string_end_o),
    .run_last_o   (run_last_o)
  );

endmodule

// ===== rtl/u8u16_front.sv =====
// Decoder front: takes UTF-8 bytes and assembles complete code points.
// Depends on u8u16_pkg; feeds the u8u16_fifo queue.
module u8u16_front
  import u8u16_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] in_byte_i,
  input  logic       final_byte_i,
  output logic       push_o,
  output entry_t     entry_o
);

  logic [PointW-1:0] partial_q, partial_d;
  logic [1:0]        left_q, left_d;
  logic              bad_q, bad_d;
  logic              emit;
  logic [PointW-1:0] point;
  logic              cont_ok;
  logic [PointW-1:0] shifted;
  logic              bad_upd;

  assign cont_ok = (in_byte_i & ContMask) == ContPat;
  assign shifted = {partial_q[PointW-7:0], in_byte_i[5:0]};
  assign bad_upd = bad_q | ~cont_ok;

  // Byte classification and next decoder state.
  always_comb begin
    partial_d = partial_q;
    left_d    = left_q;
    bad_d     = bad_q;
    emit      = 1'b0;
    point     = '0;
    if (left_q != 2'd0) begin
      // A byte inside an open sequence always counts toward its length.
      if (cont_ok) begin
        partial_d = shifted;
      end
      bad_d  = bad_upd;
      left_d = left_q - 2'd1;
      if (left_q == 2'd1) begin
        emit      = ~bad_upd;
        point     = partial_d;
        partial_d = '0;
        bad_d     = 1'b0;
      end
    end else if (in_byte_i[7] == 1'b0) begin
      emit  = 1'b1;
      point = {{(PointW-8){1'b0}}, in_byte_i};
    end else if ((in_byte_i & Lead2Mask) == Lead2Pat) begin
      partial_d = {{(PointW-5){1'b0}}, in_byte_i[4:0]};
      left_d    = 2'd1;
      bad_d     = 1'b0;
    end else if ((in_byte_i & Lead3Mask) == Lead3Pat) begin
      partial_d = {{(PointW-4){1'b0}}, in_byte_i[3:0]};
      left_d    = 2'd2;
      bad_d     = 1'b0;
    end else if ((in_byte_i & Lead4Mask) == Lead4Pat) begin
      partial_d = {{(PointW-3){1'b0}}, in_byte_i[2:0]};
      left_d    = 2'd3;
      bad_d     = 1'b0;
    end
    // The string's last byte leaves the decoder clear, dropping a cut-off sequence.
    if (final_byte_i) begin
      partial_d = '0;
      left_d    = 2'd0;
      bad_d     = 1'b0;
    end
  end

  // Queue entry: a code point, or an end marker when the last byte gives nothing.
  assign push_o        = accept_i & (emit | final_byte_i);
  assign entry_o.mark  = ~emit;
  assign entry_o.point = point;
  assign entry_o.fin   = final_byte_i;

  // Decoder state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q <= '0;
      left_q    <= 2'd0;
      bad_q     <= 1'b0;
    end else if (accept_i) begin
      partial_q <= partial_d;
      left_q    <= left_d;
      bad_q     <= bad_d;
    end
  end

endmodule

// ===== rtl/u8u16_fifo.sv =====
// Short queue of decoded entries between the front and the back.
// Depends on u8u16_pkg for the entry type and depth.
module u8u16_fifo
  import u8u16_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t wdata_i,
  input  logic   pop_i,
  output entry_t rdata_o,
  output logic   full_o,
  output logic   empty_o
);

  entry_t          mem_q [FifoDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o  = count_q == CntW'(FifoDepth);
  assign empty_o = count_q == '0;
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  // Entry storage; no reset needed for payload.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  // Pointers wrap at the depth; the fill count tracks occupancy.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(FifoDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(FifoDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

// ===== rtl/u8u16_back.sv =====
// Unit back: turns queued code points into UTF-16 units in an output register.
// Depends on u8u16_pkg; reads entries from the u8u16_fifo queue.
module u8u16_back
  import u8u16_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  entry_t      entry_i,
  input  logic        avail_i,
  output logic        take_o,
  input  logic        pop_i,
  output logic        empty_o,
  output logic [15:0] code_unit_o,
  output logic        unit_valid_o,
  output logic        string_end_o,
  output logic        run_last_o
);

  logic              out_valid_q, out_valid_d;
  logic [15:0]       unit_q, unit_d;
  logic              uvalid_q, uvalid_d;
  logic              send_q, send_d;
  logic              last_q, last_d;
  logic              second_q, second_d;
  logic              load;
  logic              is_pair;
  logic [PointW-1:0] offs;

  assign empty_o = ~out_valid_q;
  assign load    = avail_i & (~out_valid_q | pop_i);
  assign is_pair = ~entry_i.mark & (entry_i.point[PointW-1:16] != '0);
  assign offs    = entry_i.point - SuppBase;

  // A pair stays at the head of the queue until its low half is loaded for output.
  assign take_o = load & ~(is_pair & ~second_q);

  // Next output register contents.
  always_comb begin
    unit_d   = unit_q;
    uvalid_d = uvalid_q;
    send_d   = send_q;
    last_d   = last_q;
    second_d = second_q;
    if (load) begin
      if (entry_i.mark) begin
        unit_d   = '0;
        uvalid_d = 1'b0;
        send_d   = 1'b1;
        last_d   = 1'b1;
        second_d = 1'b0;
      end else if (is_pair && !second_q) begin
        unit_d   = HiSurr + {6'd0, offs[19:10]};
        uvalid_d = 1'b1;
        send_d   = 1'b0;
        last_d   = 1'b0;
        second_d = 1'b1;
      end else begin
        unit_d   = is_pair ? (LoSurr + {6'd0, offs[9:0]}) : entry_i.point[15:0];
        uvalid_d = 1'b1;
        send_d   = entry_i.fin;
        last_d   = 1'b1;
        second_d = 1'b0;
      end
    end
    out_valid_d = load | (out_valid_q & ~pop_i);
  end

  // Output register; valid and pair-state bits are reset, the unit and its flags are not.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      second_q    <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      second_q    <= second_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unit_q   <= unit_d;
    uvalid_q <= uvalid_d;
    send_q   <= send_d;
    last_q   <= last_d;
  end

  assign code_unit_o  = unit_q;
  assign unit_valid_o = uvalid_q;
  assign string_end_o = send_q;
  assign run_last_o   = last_q;

endmodule

// ===== rtl/u8u16_checker.sv =====
// Port-level checks for the UTF-8 to UTF-16BE converter, bound to the top level.
// Depends only on the top level's ports.
module u8u16_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        empty,
  input logic        pop,
  input logic [15:0] code_unit_o,
  input logic        unit_valid_o,
  input logic        string_end_o,
  input logic        run_last_o
);

  // A waiting result stays until its transfer.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(code_unit_o) && $stable(run_last_o))
    else $error("result changed before its transfer");

  // The string end always closes the byte's results.
  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && string_end_o |-> run_last_o)
    else $error("string end without run end");

  // An end marker carries no unit and ends the string.
  a_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !unit_valid_o |-> code_unit_o == 16'h0000 && string_end_o && run_last_o)
    else $error("malformed end marker");

  // Only the high half of a surrogate pair can leave a byte's results open.
  a_pair_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !run_last_o |-> unit_valid_o && code_unit_o[15:10] == 6'b110110)
    else $error("open run on a unit that is not a high surrogate");

endmodule

bind utf8_to_utf16be_converter u8u16_checker u_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .empty        (empty),
  .pop          (pop),
  .code_unit_o  (code_unit_o),
  .unit_valid_o (unit_valid_o),
  .string_end_o (string_end_o),
  .run_last_o   (run_last_o)
);
